/* src/assert_macros.svh */
// Assertion macros used by the checker.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EPP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define EPP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* src/epp_pkg.sv */
// Shared types and constants of the encoder position PID block.
// No dependencies; imported by the controller, the datapath and the top level.
package epp_pkg;

  localparam int GAIN_FRAC_BITS = 8;
  localparam int DUTY_MAX       = 255;
  localparam int DUTY_W         = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 2'd3;

  localparam logic signed [31:0] TARGET_RST = 32'sd15000;
  localparam logic signed [15:0] GAIN_P_RST = 16'sd256;
  localparam logic signed [15:0] GAIN_D_RST = 16'sd51;
  localparam logic signed [15:0] GAIN_I_RST = 16'sd0;

  // One quotient bit per step of the restoring divider.
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    MUL_ERR_ELAPSED,
    MUL_GAIN_P,
    MUL_GAIN_D,
    MUL_GAIN_I
  } epp_mul_sel_e;

  typedef struct packed {
    logic         edge_en;
    logic         start;
    logic         div_init;
    logic         div_step;
    logic         int_upd;
    logic         mul_en;
    epp_mul_sel_e mul_sel;
    logic         acc_load;
    logic         acc_add;
    logic         out_load;
  } epp_cmd_t;

  typedef struct packed {
    logic out_free;
  } epp_stat_t;

endpackage

/* src/epp_ctrl.sv */
// Sequencer of the encoder position PID block.
// Depends on epp_pkg; drives the datapath through epp_cmd_t.
module epp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_command_i,
  output logic                in_ready_o,
  input  epp_pkg::epp_stat_t  stat_i,
  output epp_pkg::epp_cmd_t   cmd_o
);
  import epp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_INT  = 3'd3;
  localparam logic [2:0] S_MD   = 3'd4;
  localparam logic [2:0] S_MI   = 3'd5;
  localparam logic [2:0] S_SUM  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0]           state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_command_i) begin
            cmd_o.start = 1'b1;
            state_d     = S_LOAD;
          end else begin
            cmd_o.edge_en = 1'b1;
          end
        end
      end
      S_LOAD: begin
        cmd_o.div_init = 1'b1;
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = MUL_ERR_ELAPSED;
        cnt_d          = '0;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = S_INT;
        end
      end
      S_INT: begin
        cmd_o.int_upd = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_GAIN_P;
        state_d       = S_MD;
      end
      S_MD: begin
        cmd_o.acc_load = 1'b1;
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = MUL_GAIN_D;
        state_d        = S_MI;
      end
      S_MI: begin
        cmd_o.acc_add = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_GAIN_I;
        state_d       = S_SUM;
      end
      S_SUM: begin
        cmd_o.acc_add = 1'b1;
        state_d       = S_FIN;
      end
      S_FIN: begin
        // Wait here until the output register can take the new word.
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

/* src/epp_datapath.sv */
// Datapath of the encoder position PID block: count, divider, shared multiplier.
// Depends on epp_pkg; sequenced by epp_ctrl through epp_cmd_t.
module epp_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  epp_pkg::epp_cmd_t               cmd_i,
  output epp_pkg::epp_stat_t              stat_o,
  input  logic                            cfg_we_i,
  input  logic [epp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [epp_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_phase_b_i,
  input  logic [15:0]                     in_elapsed_ms_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [epp_pkg::DUTY_W-1:0]      out_pwm_duty_o,
  output logic                            out_direction_o,
  output logic signed [31:0]              out_error_o,
  output logic signed [31:0]              out_control_value_o
);
  import epp_pkg::*;

  localparam int SAT_LO = 31 + GAIN_FRAC_BITS;

  logic signed [31:0] target_q;
  logic signed [15:0] gain_p_q, gain_d_q, gain_i_q;
  logic signed [31:0] count_q, prev_err_q, err_q;
  logic signed [47:0] integral_q;
  logic [15:0]        elapsed_q;
  logic [31:0]        dvd_q;
  logic [15:0]        rem_q;
  logic               neg_q;
  logic signed [63:0] prod_q, acc_q;
  logic               out_valid_q;
  logic [DUTY_W-1:0]  pwm_q;
  logic               dir_q;
  logic signed [31:0] oerr_q, u_q;

  logic signed [32:0] err_wide;
  logic signed [31:0] err_sat;
  logic signed [32:0] diff;
  logic [32:0]        diff_neg;
  logic [16:0]        rem_sh, rem_sub;
  logic               ge;
  logic signed [32:0] deriv;
  logic signed [16:0] mul_a;
  logic signed [47:0] mul_b;
  logic signed [64:0] mul_p;
  logic [49:0]        int_sum;
  logic [47:0]        int_sat;
  logic signed [31:0] u;
  logic [32:0]        u_mag;
  logic [DUTY_W-1:0]  duty;

  // Error is count minus target, clipped to the signed 32-bit range.
  assign err_wide = {count_q[31], count_q} - {target_q[31], target_q};
  assign err_sat  = (err_wide[32] != err_wide[31])
                  ? (err_wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                  : err_wide[31:0];

  // The difference of two clipped errors has a magnitude below 2^32.
  assign diff     = {err_q[31], err_q} - {prev_err_q[31], prev_err_q};
  assign diff_neg = -diff;

  assign rem_sh  = {rem_q, dvd_q[31]};
  assign rem_sub = rem_sh - {1'b0, elapsed_q};
  assign ge      = (rem_sh >= {1'b0, elapsed_q});

  // A zero elapsed time gives a zero derivative whatever the divider holds.
  always_comb begin
    if (elapsed_q == 16'd0) begin
      deriv = '0;
    end else if (neg_q) begin
      deriv = -$signed({1'b0, dvd_q});
    end else begin
      deriv = $signed({1'b0, dvd_q});
    end
  end

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_ERR_ELAPSED: begin
        mul_a = $signed({1'b0, elapsed_q});
        mul_b = {{16{err_q[31]}}, err_q};
      end
      MUL_GAIN_P: begin
        mul_a = {gain_p_q[15], gain_p_q};
        mul_b = {{16{err_q[31]}}, err_q};
      end
      MUL_GAIN_D: begin
        mul_a = {gain_d_q[15], gain_d_q};
        mul_b = {{15{deriv[32]}}, deriv};
      end
      default: begin
        mul_a = {gain_i_q[15], gain_i_q};
        mul_b = integral_q;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign int_sum = {{2{integral_q[47]}}, integral_q} + prod_q[49:0];
  assign int_sat = ((int_sum[49:47] != 3'b000) && (int_sum[49:47] != 3'b111))
                 ? (int_sum[49] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}})
                 : int_sum[47:0];

  // Dropping the fraction bits of the sum is a floor shift.
  always_comb begin
    if ((&acc_q[63:SAT_LO]) || !(|acc_q[63:SAT_LO])) begin
      u = acc_q[SAT_LO:GAIN_FRAC_BITS];
    end else if (acc_q[63]) begin
      u = 32'sh8000_0000;
    end else begin
      u = 32'sh7fff_ffff;
    end
  end

  assign u_mag = u[31] ? -{u[31], u} : {u[31], u};
  assign duty  = (u_mag > 33'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX) : u_mag[DUTY_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= TARGET_RST;
      gain_p_q   <= GAIN_P_RST;
      gain_d_q   <= GAIN_D_RST;
      gain_i_q   <= GAIN_I_RST;
      count_q    <= '0;
      prev_err_q <= '0;
      integral_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_TARGET: target_q <= cfg_data_i;
          REG_GAIN_P: gain_p_q <= cfg_data_i[15:0];
          REG_GAIN_D: gain_d_q <= cfg_data_i[15:0];
          REG_GAIN_I: gain_i_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (cmd_i.edge_en) begin
        count_q <= in_phase_b_i ? count_q + 32'sd1 : count_q - 32'sd1;
      end
      if (cmd_i.div_init) begin
        prev_err_q <= err_q;
      end
      if (cmd_i.int_upd) begin
        integral_q <= int_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      err_q     <= err_sat;
      elapsed_q <= in_elapsed_ms_i;
    end
    if (cmd_i.div_init) begin
      neg_q <= diff[32];
      dvd_q <= diff[32] ? diff_neg[31:0] : diff[31:0];
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[30:0], ge};
      rem_q <= ge ? rem_sub[15:0] : rem_sh[15:0];
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_p[63:0];
    end
    if (cmd_i.acc_load) begin
      acc_q <= prod_q;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + prod_q;
    end
    if (cmd_i.out_load) begin
      pwm_q  <= duty;
      dir_q  <= u[31];
      oerr_q <= err_q;
      u_q    <= u;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.out_free     = !out_valid_q || out_ready_i;
  assign out_valid_o         = out_valid_q;
  assign out_pwm_duty_o      = pwm_q;
  assign out_direction_o     = dir_q;
  assign out_error_o         = oerr_q;
  assign out_control_value_o = u_q;

endmodule

/* src/encoder_position_pid.sv */
// Top level of the encoder position PID block.
// Depends on epp_pkg, epp_ctrl and epp_datapath.
//
// Usage: the input channel takes one word per handshake. A word with
// command low is an encoder edge on phase A; the count moves up when
// phase B is high and down otherwise. It gives no result, so edges can
// stream in back to back while no control step is running.
// A word with command high is a control step carrying the elapsed time.
// The error is captured at the accepting edge; the block then sets up
// the divider, runs the one-bit-per-cycle restoring divider for the
// derivative, and steps through the shared multiplier and accumulator.
// The input opens again in the cycle the output word turns valid, so a
// new control step is accepted only once the previous one is finished.
// The output register holds a finished word until it is taken; encoder
// edges are still accepted meanwhile, and a further control step waits in
// its last cycle while the previous result has not been taken.
// Reset clears the count, the previous error and the integral, and loads
// the register defaults. Configuration writes take effect at once.
module encoder_position_pid (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [epp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [epp_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            in_command_i,
  input  logic                            in_phase_b_i,
  input  logic [15:0]                     in_elapsed_ms_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [epp_pkg::DUTY_W-1:0]      out_pwm_duty_o,
  output logic                            out_direction_o,
  output logic signed [31:0]              out_error_o,
  output logic signed [31:0]              out_control_value_o
);
  import epp_pkg::*;

  epp_cmd_t  cmd;
  epp_stat_t stat;

  epp_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_command_i (in_command_i),
    .in_ready_o   (in_ready_o),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  epp_datapath u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_phase_b_i        (in_phase_b_i),
    .in_elapsed_ms_i     (in_elapsed_ms_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .out_pwm_duty_o      (out_pwm_duty_o),
    .out_direction_o     (out_direction_o),
    .out_error_o         (out_error_o),
    .out_control_value_o (out_control_value_o)
  );

endmodule

/* src/epp_checker.sv */
// Port-level checks of the encoder position PID block, bound to the top level.
// Depends on epp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module epp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cfg_we_i,
  input logic [epp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input logic [epp_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            in_command_i,
  input logic                            in_phase_b_i,
  input logic [15:0]                     in_elapsed_ms_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [epp_pkg::DUTY_W-1:0]      out_pwm_duty_o,
  input logic                            out_direction_o,
  input logic signed [31:0]              out_error_o,
  input logic signed [31:0]              out_control_value_o
);
  import epp_pkg::*;

  // A stalled output word stays valid, with its error and control value stable.
  `EPP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `EPP_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i,
                  $stable(out_control_value_o) && $stable(out_error_o))

  // A control step occupies the block, so the input closes the next cycle.
  `EPP_ASSERT_NXT(a_step_busy, clk_i, rst_ni, in_valid_i && in_ready_o && in_command_i,
                  !in_ready_o)

  // Direction follows the sign of the control value.
  `EPP_ASSERT_IMP(a_dir_sign, clk_i, rst_ni, out_valid_o,
                  out_direction_o == out_control_value_o[31])

  // A small non-negative control value is passed to the duty unchanged.
  `EPP_ASSERT_IMP(a_duty_small, clk_i, rst_ni,
                  out_valid_o && (out_control_value_o[31:DUTY_W] == '0),
                  out_pwm_duty_o == out_control_value_o[DUTY_W-1:0])

endmodule

bind encoder_position_pid epp_checker u_epp_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for encoder_position_pid, built on epp_pkg.
// A directed table is run first and then random words under random gaps and stalls;
// every output word is compared field by field with a typed expectation or a PID predictor kept in step.
module testbench;
  import epp_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int SETTLE_CYCLES   = 60;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 130;

  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam longint S32_MAX   = 64'sd2147483647;
  localparam longint S32_MIN   = -64'sd2147483648;
  localparam longint INTEG_MAX = 64'sd140737488355327;
  localparam longint INTEG_MIN = -64'sd140737488355328;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              dir;
    logic [31:0]       err;
    logic [31:0]       u;
  } pid_word_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_EDGE, ROW_STEP} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]          data;
    logic                 phase_b;
    logic [15:0]          elapsed;
    logic                 has_typed;
    pid_word_t            typed_word;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  in_command_i;
  logic                  in_phase_b_i;
  logic [15:0]           in_elapsed_ms_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [DUTY_W-1:0]     out_pwm_duty_o;
  logic                  out_direction_o;
  logic signed [31:0]    out_error_o;
  logic signed [31:0]    out_control_value_o;

  encoder_position_pid dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .in_command_i        (in_command_i),
    .in_phase_b_i        (in_phase_b_i),
    .in_elapsed_ms_i     (in_elapsed_ms_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .out_pwm_duty_o      (out_pwm_duty_o),
    .out_direction_o     (out_direction_o),
    .out_error_o         (out_error_o),
    .out_control_value_o (out_control_value_o)
  );

  // Predictor state and its copy of the registers.
  logic signed [31:0] enc_count    = '0;
  longint             prev_err     = 0;
  longint             err_integral = 0;
  longint             target_l     = longint'(TARGET_RST);
  longint             kp_l         = longint'(GAIN_P_RST);
  longint             kd_l         = longint'(GAIN_D_RST);
  longint             ki_l         = longint'(GAIN_I_RST);

  pid_word_t drive_words_due[$];
  int        mismatch_count  = 0;
  int        cycle_count     = 0;
  bit        calm            = 1'b0;
  bit        work_since_idle = 1'b0;
  int        ready_hold      = 0;
  stim_row_t dir_rows[$];

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void track_edge(logic phase_b);
    if (phase_b) enc_count = enc_count + 32'sd1;
    else enc_count = enc_count - 32'sd1;
  endfunction

  function automatic pid_word_t pid_control_step(logic [15:0] elapsed);
    longint    ms, err, deriv, sum, u, mag;
    pid_word_t w;
    ms = longint'({48'd0, elapsed});
    err = clamp_to(longint'(enc_count) - target_l, S32_MIN, S32_MAX);
    // A zero interval gives no derivative; the division truncates toward zero.
    deriv = (ms == 0) ? 0 : (err - prev_err) / ms;
    err_integral = clamp_to(err_integral + err * ms, INTEG_MIN, INTEG_MAX);
    sum = kp_l * err + kd_l * deriv + ki_l * err_integral;
    u = clamp_to(sum >>> GAIN_FRAC_BITS, S32_MIN, S32_MAX);
    prev_err = err;
    mag = (u < 0) ? -u : u;
    if (mag > DUTY_MAX) mag = DUTY_MAX;
    w.duty = mag[DUTY_W-1:0];
    w.dir  = (u < 0);
    w.err  = err[31:0];
    w.u    = u[31:0];
    return w;
  endfunction

  // Mostly short idle stretches, now and then a long one.
  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 100);
  endfunction

  function automatic logic [15:0] pick_elapsed();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return 16'd0;
    if (r < 10) return 16'hFFFF;
    if (r < 30) return 16'($urandom);
    return 16'($urandom_range(1, 60));
  endfunction

  function automatic logic [31:0] pick_target();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return 32'h8000_0000;
    if (r < 10) return 32'h7FFF_FFFF;
    if (r < 25) return $urandom;
    return enc_count + 32'($urandom_range(0, 400)) - 32'd200;
  endfunction

  function automatic logic [31:0] pick_gain();
    int unsigned r;
    logic [15:0] g;
    logic [31:0] hi;
    r = $urandom_range(0, 99);
    hi = $urandom;
    if (r < 20) begin
      case ($urandom_range(0, 3))
        0: g = 16'h8000;
        1: g = 16'h7FFF;
        2: g = 16'h0000;
        default: g = 16'h0100;
      endcase
    end else if (r < 65) begin
      g = 16'($urandom_range(0, 1024)) - 16'd512;
    end else begin
      g = 16'($urandom);
    end
    return {hi[31:16], g};
  endfunction

  function automatic stim_row_t row_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  function automatic stim_row_t row_edge(logic phase_b);
    stim_row_t r;
    r = '0;
    r.kind    = ROW_EDGE;
    r.phase_b = phase_b;
    return r;
  endfunction

  function automatic stim_row_t row_step(logic [15:0] elapsed);
    stim_row_t r;
    r = '0;
    r.kind    = ROW_STEP;
    r.elapsed = elapsed;
    return r;
  endfunction

  function automatic stim_row_t row_chk(logic [15:0] elapsed, logic [7:0] duty, logic dir,
                                        logic signed [31:0] err, logic signed [31:0] u);
    stim_row_t r;
    r = row_step(elapsed);
    r.has_typed       = 1'b1;
    r.typed_word.duty = duty;
    r.typed_word.dir  = dir;
    r.typed_word.err  = err;
    r.typed_word.u    = u;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, $signed(want), $signed(got));
      mismatch_count++;
    end
  endfunction

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_TARGET: target_l = longint'($signed(data));
      REG_GAIN_P: kp_l = longint'($signed(data[15:0]));
      REG_GAIN_D: kd_l = longint'($signed(data[15:0]));
      REG_GAIN_I: ki_l = longint'($signed(data[15:0]));
      default: ;
    endcase
  endtask

  // Sends one word; the prediction is made at the edge that accepts it.
  task automatic push_word(logic cmd, logic phase_b, logic [15:0] elapsed, int gap,
                           logic has_typed, pid_word_t typed_word);
    pid_word_t w;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    in_command_i    <= cmd;
    in_phase_b_i    <= phase_b;
    in_elapsed_ms_i <= elapsed;
    do @(posedge clk_i); while (!in_ready_o);
    work_since_idle = 1'b1;
    if (cmd == CMD_EDGE) begin
      track_edge(phase_b);
    end else begin
      w = pid_control_step(elapsed);
      drive_words_due.push_back(has_typed ? typed_word : w);
    end
  endtask

  // Edges give no word, so after the last one arrives the block may still be busy.
  task automatic settle_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (drive_words_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    work_since_idle = 1'b0;
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL encoder_position_pid");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    pid_word_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (drive_words_due.size() == 0) begin
        $display("%0t: output word with none expected, control value %0d", $time,
                 out_control_value_o);
        mismatch_count++;
      end else begin
        w = drive_words_due.pop_front();
        check_field("pwm_duty", 32'(w.duty), 32'(out_pwm_duty_o));
        check_field("direction", 32'(w.dir), 32'(out_direction_o));
        check_field("error", w.err, out_error_o);
        check_field("control_value", w.u, out_control_value_o);
      end
    end
  end

  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (ready_hold > 0) begin
        ready_hold--;
      end else if (calm) begin
        out_ready_i <= 1'b1;
        ready_hold = 20;
      end else if ($urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        ready_hold = idle_len();
      end else begin
        out_ready_i <= 1'b1;
        ready_hold = $urandom_range(0, 10);
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    in_command_i    = CMD_EDGE;
    in_phase_b_i    = 1'b0;
    in_elapsed_ms_i = '0;

    dir_rows = '{
      // Reset defaults: target 15000, proportional 1.0, derivative 0.2.
      row_chk(16'd1, 8'd255, 1'b1, -32'sd15000, -32'sd17989),
      row_chk(16'd0, 8'd255, 1'b1, -32'sd15000, -32'sd15000),
      row_edge(1'b1), row_edge(1'b1), row_edge(1'b0),
      row_cfg(REG_TARGET, 32'd0), row_cfg(REG_GAIN_P, 32'd1),
      row_cfg(REG_GAIN_D, 32'd0), row_cfg(REG_GAIN_I, 32'd0),
      // A gain of 1/256 drops positive fractions to zero and floors negative ones.
      row_chk(16'd1, 8'd0, 1'b0, 32'sd1, 32'sd0),
      row_edge(1'b0), row_edge(1'b0),
      row_chk(16'd1, 8'd1, 1'b1, -32'sd1, -32'sd1),
      row_cfg(REG_TARGET, 32'h8000_0000), row_cfg(REG_GAIN_P, 32'h0000_7FFF),
      row_cfg(REG_GAIN_D, 32'hFFFF_8000), row_cfg(REG_GAIN_I, 32'h0000_7FFF),
      // Error at the top of its range, then past it, with the integral running into its limit.
      row_step(16'hFFFF), row_edge(1'b1), row_step(16'hFFFF), row_step(16'hFFFF),
      row_cfg(REG_TARGET, 32'h7FFF_FFFF), row_cfg(REG_GAIN_P, 32'h0000_8000),
      row_cfg(REG_GAIN_D, 32'h0000_7FFF), row_cfg(REG_GAIN_I, 32'h0000_8000),
      row_step(16'hFFFF), row_edge(1'b0), row_edge(1'b0),
      row_step(16'hFFFF), row_step(16'hFFFF), row_step(16'hFFFF), row_step(16'hFFFF)
    };

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[k]) begin
      case (dir_rows[k].kind)
        ROW_CFG: begin
          if (work_since_idle) settle_idle();
          cfg_write(dir_rows[k].idx, dir_rows[k].data);
        end
        ROW_EDGE: push_word(CMD_EDGE, dir_rows[k].phase_b, 16'($urandom), idle_len(),
                            1'b0, '0);
        default: push_word(CMD_STEP, 1'($urandom), dir_rows[k].elapsed, idle_len(),
                           dir_rows[k].has_typed, dir_rows[k].typed_word);
      endcase
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle_idle();
      calm = (ph == 2 || ph == 5);
      cfg_write(REG_TARGET, pick_target());
      cfg_write(REG_GAIN_P, pick_gain());
      cfg_write(REG_GAIN_D, pick_gain());
      cfg_write(REG_GAIN_I, pick_gain());
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        push_word(($urandom_range(0, 99) < 55) ? CMD_STEP : CMD_EDGE, 1'($urandom),
                  pick_elapsed(), calm ? 0 : idle_len(), 1'b0, '0);
      end
    end

    settle_idle();
    if (mismatch_count == 0) begin
      $display("PASS encoder_position_pid");
    end else begin
      $display("FAIL encoder_position_pid");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/epp_pkg.sv
src/epp_ctrl.sv
src/epp_datapath.sv
src/encoder_position_pid.sv
src/epp_checker.sv
tb/testbench.sv
